// File: design/mclp_pkg.sv
`timescale 1ns / 1ps
// Shared types, character codes and keyword tables for the motion command line parser.
package mclp_pkg;

	localparam int LINE_CHARS_DEF = 31;
	localparam int NUM_BITS       = 24;
	localparam int MAG_BITS       = NUM_BITS - 1;
	localparam int RAD_BITS       = 36;
	localparam logic [MAG_BITS-1:0] NUM_MAX = '1;
	// pi/180 in Q0.32, rounded
	localparam logic [26:0] DEG_TO_RAD_Q32 = 27'd74961321;

	localparam logic [7:0] CHAR_NL    = 8'h0A;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_C     = 8'h43;
	localparam logic [7:0] CHAR_G     = 8'h47;
	localparam logic [7:0] CHAR_K     = 8'h4B;
	localparam logic [7:0] CHAR_R     = 8'h52;
	localparam logic [7:0] CHAR_S     = 8'h53;
	localparam logic [7:0] CHAR_T     = 8'h54;

	localparam logic [2:0] PHASE_DONE = 3'd6;

	typedef enum logic [3:0] {
		KIND_STOP     = 4'd0,
		KIND_GOTO_XYZ = 4'd1,
		KIND_GOTO_XY  = 4'd2,
		KIND_ROTATE   = 4'd3,
		KIND_SET_POS  = 4'd4,
		KIND_TUNE     = 4'd5,
		KIND_TUNE_BAD = 4'd6,
		KIND_PAUSE    = 4'd7,
		KIND_RESUME   = 4'd8,
		KIND_OTHER    = 4'd9
	} kind_t;

	typedef enum logic [1:0] {
		GAIN_ROT     = 2'd0,
		GAIN_TRANS   = 2'd1,
		GAIN_HEADING = 2'd2,
		GAIN_INVALID = 2'd3
	} gain_t;

	typedef struct packed {
		kind_t                       kind;
		gain_t                       gain;
		logic signed [NUM_BITS-1:0]  x;
		logic signed [NUM_BITS-1:0]  y;
		logic signed [NUM_BITS-1:0]  ang;
		logic                        ctrl_rst;
	} line_res_t;

	// "CMD:STOP"
	function automatic logic [7:0] kw_stop_char(input logic [2:0] idx);
		logic [7:0] ch;
		case (idx)
			3'd0: ch = 8'h43;
			3'd1: ch = 8'h4D;
			3'd2: ch = 8'h44;
			3'd3: ch = 8'h3A;
			3'd4: ch = 8'h53;
			3'd5: ch = 8'h54;
			3'd6: ch = 8'h4F;
			3'd7: ch = 8'h50;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	// "CMD:GO"; entries past the keyword are gated off by position
	function automatic logic [7:0] kw_go_char(input logic [2:0] idx);
		logic [7:0] ch;
		case (idx)
			3'd0: ch = 8'h43;
			3'd1: ch = 8'h4D;
			3'd2: ch = 8'h44;
			3'd3: ch = 8'h3A;
			3'd4: ch = 8'h47;
			3'd5: ch = 8'h4F;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

// File: design/mclp_parse.sv
`timescale 1ns / 1ps
// Running line parse state and end-of-line classification.
module mclp_parse
	import mclp_pkg::*;
#(
	parameter int LINE_CHARS = LINE_CHARS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_acc,
	input  logic [7:0] rx_byte,
	output logic       line_end,
	output line_res_t  line_res
);

	localparam int POS_W = $clog2(LINE_CHARS + 1);
	localparam int SUM_W = MAG_BITS + 4;

	logic [POS_W-1:0]          pos_q;
	logic [7:0]                cmd_q;
	logic [7:0]                sel_q;
	logic [2:0]                phase_q;
	logic                      neg_q;
	logic [MAG_BITS-1:0]       acc_q;
	logic signed [NUM_BITS-1:0] vals_q [3];
	logic [1:0]                kw_q;

	logic                      is_nl, in_line, is_digit, is_minus, phase_done;
	logic [SUM_W-1:0]          acc_sum;
	logic [MAG_BITS-1:0]       acc_nxt;
	logic signed [NUM_BITS-1:0] fin_val;
	logic [1:0]                fin_idx;
	logic [2:0]                fin_phase;
	logic signed [NUM_BITS-1:0] fv [3];
	logic                      stop_hit, go_hit;

	always_comb begin
		is_nl      = (rx_byte == CHAR_NL);
		in_line    = (pos_q < POS_W'(LINE_CHARS));
		is_digit   = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
		is_minus   = (rx_byte == CHAR_MINUS);
		phase_done = (phase_q >= PHASE_DONE);

		// acc * 10 + digit, then saturate
		acc_sum = (SUM_W'(acc_q) << 3) + (SUM_W'(acc_q) << 1)
			+ SUM_W'(rx_byte[3:0]);
		acc_nxt = (acc_sum > SUM_W'(NUM_MAX)) ? NUM_MAX : acc_sum[MAG_BITS-1:0];

		fin_val   = neg_q ? -$signed({1'b0, acc_q}) : $signed({1'b0, acc_q});
		fin_idx   = phase_q[2:1];
		fin_phase = {fin_idx + 2'd1, 1'b0};

		for (int i = 0; i < 3; i++) begin
			fv[i] = (!phase_done && fin_idx == 2'(i)) ? fin_val : vals_q[i];
		end

		stop_hit = (pos_q < POS_W'(8)) && (rx_byte == kw_stop_char(pos_q[2:0]));
		go_hit   = (pos_q < POS_W'(6)) && (rx_byte == kw_go_char(pos_q[2:0]));
	end

	assign line_end = byte_acc && is_nl;

	// classification uses the fields as finished by this newline
	always_comb begin
		line_res          = '0;
		line_res.ctrl_rst = 1'b1;
		if (kw_q[0] && pos_q == POS_W'(8)) begin
			line_res.kind     = KIND_PAUSE;
			line_res.ctrl_rst = 1'b0;
		end else if (kw_q[1] && pos_q == POS_W'(6)) begin
			line_res.kind     = KIND_RESUME;
			line_res.ctrl_rst = 1'b0;
		end else begin
			case (cmd_q)
				CHAR_SPACE: line_res.kind = KIND_STOP;
				CHAR_G: begin
					line_res.kind = KIND_GOTO_XYZ;
					line_res.x    = fv[0];
					line_res.y    = fv[1];
					line_res.ang  = fv[2];
				end
				CHAR_T: begin
					line_res.kind = KIND_GOTO_XY;
					line_res.x    = fv[0];
					line_res.y    = fv[1];
				end
				CHAR_R: begin
					line_res.kind = KIND_ROTATE;
					line_res.ang  = fv[0];
				end
				CHAR_S: begin
					line_res.kind = KIND_SET_POS;
					line_res.x    = fv[0];
					line_res.y    = fv[1];
					line_res.ang  = fv[2];
				end
				CHAR_K: begin
					line_res.kind = KIND_TUNE;
					case (sel_q)
						CHAR_R: line_res.gain = GAIN_ROT;
						CHAR_T: line_res.gain = GAIN_TRANS;
						CHAR_C: line_res.gain = GAIN_HEADING;
						default: begin
							line_res.gain = GAIN_INVALID;
							line_res.kind = KIND_TUNE_BAD;
						end
					endcase
				end
				default: line_res.kind = KIND_OTHER;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			cmd_q   <= '0;
			sel_q   <= '0;
			phase_q <= '0;
			neg_q   <= 1'b0;
			acc_q   <= '0;
			kw_q    <= 2'b11;
			for (int i = 0; i < 3; i++) vals_q[i] <= '0;
		end else if (byte_acc) begin
			if (is_nl) begin
				pos_q   <= '0;
				cmd_q   <= '0;
				sel_q   <= '0;
				phase_q <= '0;
				neg_q   <= 1'b0;
				acc_q   <= '0;
				kw_q    <= 2'b11;
				for (int i = 0; i < 3; i++) vals_q[i] <= '0;
			end else if (in_line) begin
				pos_q <= pos_q + POS_W'(1);
				if (!stop_hit) kw_q[0] <= 1'b0;
				if (!go_hit)   kw_q[1] <= 1'b0;
				if (pos_q == '0) begin
					cmd_q <= rx_byte;
				end else if (pos_q == POS_W'(1)) begin
					sel_q <= rx_byte;
				end else if (!phase_done) begin
					if (!phase_q[0] && is_minus) begin
						neg_q      <= 1'b1;
						phase_q[0] <= 1'b1;
					end else if (is_digit) begin
						acc_q      <= acc_nxt;
						phase_q[0] <= 1'b1;
					end else begin
						vals_q[fin_idx] <= fin_val;
						phase_q         <= fin_phase;
						neg_q           <= 1'b0;
						acc_q           <= '0;
					end
				end
			end
		end
	end

endmodule

// File: design/mclp_angle.sv
`timescale 1ns / 1ps
// Degrees to Q20.16 radians: magnitude times pi/180, rounded half up, sign restored.
module mclp_angle
	import mclp_pkg::*;
(
	input  logic signed [NUM_BITS-1:0] deg,
	output logic signed [RAD_BITS-1:0] rad
);

	localparam int PROD_W = MAG_BITS + 27;

	logic                neg;
	logic [MAG_BITS-1:0] abs_deg;
	logic [PROD_W-1:0]   prod;
	logic [PROD_W-1:0]   rnd;
	logic [RAD_BITS-1:0] mag_rad;

	always_comb begin
		neg     = deg[NUM_BITS-1];
		// |deg| stays below 2^23, so the magnitude fits without the sign bit
		abs_deg = neg ? MAG_BITS'(-deg) : MAG_BITS'(deg);
		prod    = PROD_W'(abs_deg) * PROD_W'(DEG_TO_RAD_Q32);
		rnd     = prod + PROD_W'(17'h08000);
		mag_rad = RAD_BITS'(rnd >> 16);
		rad     = neg ? -$signed(mag_rad) : $signed(mag_rad);
	end

endmodule

// File: design/motion_command_line_parser_core.sv
`timescale 1ns / 1ps
// Top level of the motion command line parser: stream ports, result stages.
// Throughput: one received byte per clock, sustained while the result side keeps up.
// Path: an accepted newline's result goes into the line result register, then through
//   the radian multiply into the output register, and from there shows on m_*.
// Bytes other than newline produce no result and only update the parse state.
// Reset (arst_n low, asynchronous): parse state returns to start of line, both
//   result stages empty.
module motion_command_line_parser_core
	import mclp_pkg::*;
#(
	parameter int LINE_CHARS = LINE_CHARS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] rx_byte
	output logic         m_tvalid,
	input  logic         m_tready,
	// [23:0] x_value, [47:24] y_value, [71:48] angle_degrees,
	// [107:72] angle_radians_q16, [108] controllers_reset, [111:109] zero
	output logic [111:0] m_tdata,
	output logic [5:0]   m_tuser    // [3:0] command_kind, [5:4] gain_set
);

	logic       byte_acc;
	logic       line_end;
	line_res_t  line_res;

	// stage 1: classified line result
	logic       vld_s1;
	line_res_t  res_s1;

	// stage 2: output register
	logic                        vld_s2;
	line_res_t                   res_s2;
	logic signed [RAD_BITS-1:0]  rad_s2;
	logic signed [RAD_BITS-1:0]  rad_comb;

	logic ready_s2, ready_s1;

	// Each stage moves when the one after it is free or draining this cycle.
	assign ready_s2 = !vld_s2 || m_tready;
	assign ready_s1 = !vld_s1 || ready_s2;
	assign s_tready = ready_s1;
	assign byte_acc = s_tvalid && s_tready;

	mclp_parse #(
		.LINE_CHARS(LINE_CHARS)
	) u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_acc (byte_acc),
		.rx_byte  (s_tdata),
		.line_end (line_end),
		.line_res (line_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (line_end) begin
			vld_s1 <= 1'b1;
		end else if (ready_s2) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (line_end) begin
			res_s1 <= line_res;
		end
	end

	mclp_angle u_angle (
		.deg (res_s1.ang),
		.rad (rad_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (ready_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && vld_s1) begin
			res_s2 <= res_s1;
			rad_s2 <= rad_comb;
		end
	end

	assign m_tvalid = vld_s2;
	assign m_tuser  = {res_s2.gain, res_s2.kind};
	assign m_tdata  = {3'b000, res_s2.ctrl_rst, rad_s2, res_s2.ang, res_s2.y, res_s2.x};

endmodule

// File: dv/mclp_line_checker.sv
`timescale 1ns / 1ps
// Line result checker for the motion command line parser: predicts and compares results.
module mclp_line_checker
	import mclp_pkg::*;
#(
	parameter int LINE_CHARS = LINE_CHARS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [7:0]   s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [111:0] m_tdata,
	input  logic [5:0]   m_tuser,
	output int           fail_cnt,
	output int           pending_cnt
);

	localparam logic [63:0] STOP_WORD = "CMD:STOP";
	localparam logic [47:0] GO_WORD   = "CMD:GO";

	typedef struct {
		kind_t                       kind;
		gain_t                       gain;
		logic signed [NUM_BITS-1:0]  x;
		logic signed [NUM_BITS-1:0]  y;
		logic signed [NUM_BITS-1:0]  ang;
		logic signed [RAD_BITS-1:0]  rad;
		logic                        ctrl_rst;
	} line_result_t;

	line_result_t lines_due[$];

	// running parse state of the current line
	int unsigned col;
	logic [7:0]  cmd_ch;
	logic [7:0]  sel_ch;
	logic [2:0]  phase;     // 2*field + sign-or-digit-seen, PHASE_DONE after third field
	logic        neg;
	logic [63:0] acc;
	logic [63:0] vals [3];
	logic        stop_ok;
	logic        go_ok;

	function automatic void clear_line();
		col     = 0;
		cmd_ch  = '0;
		sel_ch  = '0;
		phase   = '0;
		neg     = 1'b0;
		acc     = '0;
		vals[0] = '0;
		vals[1] = '0;
		vals[2] = '0;
		stop_ok = 1'b1;
		go_ok   = 1'b1;
	endfunction

	function automatic void close_field();
		if (phase < PHASE_DONE) begin
			vals[phase[2:1]] = neg ? -acc : acc;
			phase = {phase[2:1] + 2'd1, 1'b0};
		end
		neg = 1'b0;
		acc = '0;
	endfunction

	function automatic void parse_number_char(input logic [7:0] c);
		if (phase >= PHASE_DONE)
			return;
		if (!phase[0] && c == CHAR_MINUS) begin
			neg = 1'b1;
			phase[0] = 1'b1;
		end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
			acc = acc * 10 + 64'(c - CHAR_ZERO);
			if (acc > 64'(NUM_MAX))
				acc = 64'(NUM_MAX);
			phase[0] = 1'b1;
		end else begin
			close_field();
		end
	endfunction

	// |deg| < 2^23, so the product needs no split into high and low parts
	function automatic logic signed [RAD_BITS-1:0] deg_to_q16_rad(
		input logic signed [NUM_BITS-1:0] deg);
		logic [63:0] mag;
		logic [63:0] prod;
		mag  = deg[NUM_BITS-1] ? 64'(-deg) : 64'(deg);
		prod = (mag * 64'(DEG_TO_RAD_Q32) + 64'h8000) >> 16;
		return deg[NUM_BITS-1] ? -prod[RAD_BITS-1:0] : prod[RAD_BITS-1:0];
	endfunction

	function automatic void take_byte(input logic [7:0] c);
		int unsigned  p;
		int unsigned  q;
		line_result_t r;
		p = col;
		if (c != CHAR_NL) begin
			if (p < LINE_CHARS) begin
				if (p == 0)
					cmd_ch = c;
				else if (p == 1)
					sel_ch = c;
				else
					parse_number_char(c);
				if (p >= 8 || c != STOP_WORD[8*(7-p[2:0]) +: 8])
					stop_ok = 1'b0;
				q = (p < 6) ? p : 0;
				if (p >= 6 || c != GO_WORD[8*(5-q) +: 8])
					go_ok = 1'b0;
				col = p + 1;
			end
			return;
		end

		close_field();
		r.kind     = KIND_OTHER;
		r.gain     = GAIN_ROT;   // gain reads 0 outside tune lines
		r.x        = '0;
		r.y        = '0;
		r.ang      = '0;
		r.ctrl_rst = 1'b1;
		if (stop_ok && p == 8) begin
			r.kind     = KIND_PAUSE;
			r.ctrl_rst = 1'b0;
		end else if (go_ok && p == 6) begin
			r.kind     = KIND_RESUME;
			r.ctrl_rst = 1'b0;
		end else begin
			case (cmd_ch)
				CHAR_SPACE: r.kind = KIND_STOP;
				CHAR_G: begin
					r.kind = KIND_GOTO_XYZ;
					r.x    = vals[0][NUM_BITS-1:0];
					r.y    = vals[1][NUM_BITS-1:0];
					r.ang  = vals[2][NUM_BITS-1:0];
				end
				CHAR_T: begin
					r.kind = KIND_GOTO_XY;
					r.x    = vals[0][NUM_BITS-1:0];
					r.y    = vals[1][NUM_BITS-1:0];
				end
				CHAR_R: begin
					r.kind = KIND_ROTATE;
					r.ang  = vals[0][NUM_BITS-1:0];
				end
				CHAR_S: begin
					r.kind = KIND_SET_POS;
					r.x    = vals[0][NUM_BITS-1:0];
					r.y    = vals[1][NUM_BITS-1:0];
					r.ang  = vals[2][NUM_BITS-1:0];
				end
				CHAR_K: begin
					r.kind = KIND_TUNE;
					case (sel_ch)
						CHAR_R:  r.gain = GAIN_ROT;
						CHAR_T:  r.gain = GAIN_TRANS;
						CHAR_C:  r.gain = GAIN_HEADING;
						default: begin
							r.gain = GAIN_INVALID;
							r.kind = KIND_TUNE_BAD;
						end
					endcase
				end
				default: r.kind = KIND_OTHER;
			endcase
		end
		r.rad = deg_to_q16_rad(r.ang);
		lines_due.push_back(r);
		clear_line();
	endfunction

	function automatic void check_result();
		line_result_t e;
		if (lines_due.size() == 0) begin
			fail_cnt++;
			if (fail_cnt <= 10)
				$display("%0t: result transaction with none expected: kind=%0d data=%h",
					$time, m_tuser[3:0], m_tdata);
			return;
		end
		e = lines_due.pop_front();
		if (m_tuser[3:0] !== e.kind || m_tuser[5:4] !== e.gain
			|| m_tdata[23:0] !== e.x || m_tdata[47:24] !== e.y
			|| m_tdata[71:48] !== e.ang || m_tdata[107:72] !== e.rad
			|| m_tdata[108] !== e.ctrl_rst || m_tdata[111:109] !== 3'b000) begin
			fail_cnt++;
			if (fail_cnt <= 10) begin
				$display("%0t: line result mismatch", $time);
				$display("  exp kind=%0d gain=%0d x=%0d y=%0d ang=%0d rad=%0d rst=%0b pad=0",
					e.kind, e.gain, e.x, e.y, e.ang, e.rad, e.ctrl_rst);
				$display("  got kind=%0d gain=%0d x=%0d y=%0d ang=%0d rad=%0d rst=%0b pad=%0d",
					m_tuser[3:0], m_tuser[5:4], $signed(m_tdata[23:0]),
					$signed(m_tdata[47:24]), $signed(m_tdata[71:48]),
					$signed(m_tdata[107:72]), m_tdata[108], m_tdata[111:109]);
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_line();
			lines_due.delete();
			pending_cnt <= 0;
		end else begin
			// a newline result never leaves in the cycle it is taken, so compare first
			if (m_tvalid && m_tready)
				check_result();
			if (s_tvalid && s_tready)
				take_byte(s_tdata);
			pending_cnt <= lines_due.size();
		end
	end

endmodule

// File: dv/tb_motion_command_line_parser_core.sv
`timescale 1ns / 1ps
// Testbench top for the motion command line parser: byte stimulus, handshake pacing, verdict.
module tb_motion_command_line_parser_core;
	import mclp_pkg::*;

	// characters used only by the stimulus
	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_COMMA = 8'h2C;
	localparam logic [7:0] CHAR_COLON = 8'h3A;

	logic         clk      = 1'b0;
	logic         arst_n   = 1'b0;
	logic         s_tvalid = 1'b0;
	logic [7:0]   s_tdata  = '0;
	logic         m_tready = 1'b0;
	logic         s_tready;
	logic         m_tvalid;
	logic [111:0] m_tdata;
	logic [5:0]   m_tuser;

	int fail_cnt;
	int pending_cnt;
	int gap_pct   = 0;   // chance per cycle that the byte source holds off
	int stall_pct = 0;   // chance per cycle that the result sink stalls
	int bytes_sent = 0;

	motion_command_line_parser_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	mclp_line_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.fail_cnt    (fail_cnt),
		.pending_cnt (pending_cnt)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Result sink: one draw per cycle, so stalls land on every phase of a line.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// Safety net; a healthy run ends far earlier (~1.5k bytes).
	initial begin
		#5_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	// One byte transaction. tvalid stays high into the next byte when no gap is drawn.
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic send_line(input string s);
		send_text(s);
		send_byte(CHAR_NL);
	endtask

	// Hold the source off until every predicted result has been taken.
	// pending_cnt is updated by NBA, so the first read waits for a clock edge.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_cnt != 0)
			@(posedge clk);
	endtask

	// Mostly well-formed command lines with random numbers and separators;
	// the rest are keyword near-misses and raw byte noise.
	task automatic send_random_line();
		int         pick;
		int         mode;
		int         cut;
		int         idx;
		int         ndig;
		logic [7:0] cmd;
		logic [7:0] c;
		string      word;
		pick = $urandom_range(99);
		if (pick < 8) begin
			if ($urandom_range(1) != 0)
				word = "CMD:STOP";
			else
				word = "CMD:GO";
			mode = $urandom_range(3);   // exact, truncated, one char off, one char extra
			cut  = (mode == 1) ? $urandom_range(1, word.len() - 1) : word.len();
			idx  = $urandom_range(word.len() - 1);
			for (int i = 0; i < cut; i++) begin
				c = word[i];
				if (mode == 2 && i == idx)
					c = 8'($urandom_range(255));
				send_byte(c);
			end
			if (mode == 3)
				send_byte(8'($urandom_range(255)));
		end else if (pick < 15) begin
			repeat ($urandom_range(40))
				send_byte(8'($urandom_range(255)));
		end else begin
			case ($urandom_range(6))
				0:       cmd = CHAR_SPACE;
				1:       cmd = CHAR_G;
				2:       cmd = CHAR_T;
				3:       cmd = CHAR_R;
				4:       cmd = CHAR_S;
				5:       cmd = CHAR_K;
				default: cmd = 8'($urandom_range(255));
			endcase
			send_byte(cmd);
			if (cmd == CHAR_K) begin
				case ($urandom_range(3))
					0:       send_byte(CHAR_R);
					1:       send_byte(CHAR_T);
					2:       send_byte(CHAR_C);
					default: send_byte(8'($urandom_range(255)));
				endcase
			end else begin
				send_byte(($urandom_range(3) == 0) ? 8'($urandom_range(255)) : CHAR_SPACE);
			end
			repeat ($urandom_range(4)) begin
				if ($urandom_range(3) == 0)
					send_byte(CHAR_MINUS);
				// mostly short numbers, now and then long enough to saturate
				ndig = ($urandom_range(9) == 0) ? $urandom_range(5, 12) : $urandom_range(4);
				repeat (ndig)
					send_byte(CHAR_ZERO + 8'($urandom_range(9)));
				if ($urandom_range(7) != 0) begin
					case ($urandom_range(5))
						0:       send_byte(CHAR_COMMA);
						1:       send_byte(CHAR_COLON);
						2:       send_byte(CHAR_MINUS);
						3:       send_byte(8'($urandom_range(255)));
						default: send_byte(CHAR_SPACE);
					endcase
				end
			end
		end
		send_byte(CHAR_NL);
	endtask

	task automatic run_phase(input int gap, input int stall, input int upto);
		gap_pct   = gap;
		stall_pct = stall;
		while (bytes_sent < upto)
			send_random_line();
		drain();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed lines: every kind, selectors, keyword edges, sign and size extremes.
		send_line("CMD:STOP");
		send_line("CMD:GO");
		send_line("CMD:STO");
		send_line("CMD:GOX");
		send_line(" ");
		send_line("G 12,-34,56");
		send_line("T -7 8");
		send_line("R -90");
		send_line("S 1 2 3");
		send_line("KR");
		send_line("KT 5");
		send_line("KC");
		send_line("KX");
		send_line("Q 1 2 3");
		send_byte(CHAR_NL);                        // empty line
		send_line("G ,5,6");                       // first field ends at once
		send_line("R - 4");                        // lone minus
		send_line("G 99999999 -99999999 8388608");  // saturation
		send_line("R 8388607");
		send_line("R -8388607");
		send_line("T 5");                          // second field never reached
		send_line("S 7 8 9012345678901234567890123456789");  // past the line length
		send_text("G 1");
		send_byte(CHAR_NUL);
		send_line("2 3");
		send_text("R 45");
		send_byte(CHAR_CR);
		send_byte(CHAR_NL);
		drain();

		run_phase(0, 0, 400);
		run_phase(52, 0, 750);
		run_phase(0, 52, 1100);
		run_phase(17, 17, 1450);

		// give any stray results a chance to show before the verdict
		repeat (20) @(posedge clk);
		if (fail_cnt == 0 && pending_cnt == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
